[rtl/dpf_pkg.sv]
// Package for the duplicate packet filter: shared constants, register index
// codes and the command/status structs between controller and datapath.
// No dependencies.
package dpf_pkg;

   // Default history depth
   localparam int HISTORY_ENTRIES_DFLT = 5;

   // Field widths
   localparam int ADDR_W    = 32;
   localparam int ID_W      = 8;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_W     = 16;

   // Register reset values and special IDs
   localparam logic [CSR_W-1:0] HOLD_RESET = 16'd200;
   localparam logic [ID_W-1:0]  BEACON_ID  = 8'hFF;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_ADDRESS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME      = 4'd1;

   // Request operation codes
   localparam logic FUNC_JUDGE = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the request, start a new walk
      logic check;     // clear or source-address check
      logic step;      // evaluate the entry under the walk index
      logic store;     // write the new ID into the chosen slot
      logic rsp_load;  // move the result to the output register
   } dpf_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_clear;    // captured request is a clear
      logic foreign;     // source differs from the configured peer
      logic hit;         // current entry is live and matches the ID
      logic last_entry;  // walk index is on the final entry
      logic rsp_free;    // output register can take a result
   } dpf_status_type;

endpackage

[rtl/duplicate_packet_filter_top.sv]
// Top level of the duplicate packet filter: joins controller and datapath.
// Depends on dpf_pkg, dpf_ctrl and dpf_datapath.
//
// The filter keeps a short history of packet IDs from one configured peer
// and answers every request with a single accept bit. A clear request or a
// packet from another source goes from the check state straight to the
// response. A judge request walks the history one entry per clock: a
// duplicate answers once its matching entry is reached, a new ID only
// after the last entry has been walked and the ID stored. The walk of the
// table by one compare unit sets these delays. One request is in work
// at a time; a finished result waits in the output register while the next
// request is taken. Configuration writes are taken in any cycle.
module duplicate_packet_filter_top #(
   parameter int HISTORY_ENTRIES = dpf_pkg::HISTORY_ENTRIES_DFLT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [dpf_pkg::ADDR_W-1:0]    req_src_address,
   input  logic [dpf_pkg::ID_W-1:0]      req_packet_id,
   input  logic [dpf_pkg::TIME_W-1:0]    req_now_ms,
   input  logic                          req_link_connected,
   input  logic                          req_protect_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accept,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dpf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dpf_pkg::CSR_W-1:0]     csr_data
);
   import dpf_pkg::*;

   dpf_cmd_type    cmd;
   dpf_status_type status;

   assign csr_ready = 1'b1;

   dpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dpf_datapath #(
      .HISTORY_ENTRIES (HISTORY_ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_func           (req_func),
      .req_src_address    (req_src_address),
      .req_packet_id      (req_packet_id),
      .req_now_ms         (req_now_ms),
      .req_link_connected (req_link_connected),
      .req_protect_mode   (req_protect_mode),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accept         (rsp_accept),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

[rtl/dpf_ctrl.sv]
// Controller for the duplicate packet filter: sequences capture, check,
// entry walk, store and response. Depends on dpf_pkg.
module dpf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dpf_pkg::dpf_status_type status,
   output dpf_pkg::dpf_cmd_type    cmd
);
   import dpf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_STORE = 5'b01000,
      ST_DONE  = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.is_clear || status.foreign) state_in = ST_DONE;
            else                                   state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (status.hit)             state_in = ST_DONE;
            else if (status.last_entry) state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

[rtl/dpf_datapath.sv]
// Datapath for the duplicate packet filter: request latch, configuration
// registers, history table, walk registers and output register. Depends on dpf_pkg.
module dpf_datapath #(
   parameter int HISTORY_ENTRIES = dpf_pkg::HISTORY_ENTRIES_DFLT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_func,
   input  logic [dpf_pkg::ADDR_W-1:0]      req_src_address,
   input  logic [dpf_pkg::ID_W-1:0]        req_packet_id,
   input  logic [dpf_pkg::TIME_W-1:0]      req_now_ms,
   input  logic                            req_link_connected,
   input  logic                            req_protect_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_accept,
   input  logic                            csr_valid,
   input  logic [dpf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dpf_pkg::CSR_W-1:0]       csr_data,
   input  dpf_pkg::dpf_cmd_type            cmd,
   output dpf_pkg::dpf_status_type         status
);
   import dpf_pkg::*;

   localparam int IDX_W = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_ENTRIES - 1);

   // Latched request
   logic              func_ff;
   logic [ADDR_W-1:0] src_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] now_ff;
   logic              pin_new_ff;

   // Configuration
   logic [CSR_W-1:0] target_ff;
   logic [CSR_W-1:0] hold_ff;

   // History table
   logic              valid_ff [HISTORY_ENTRIES];
   logic [ID_W-1:0]   ent_id_ff [HISTORY_ENTRIES];
   logic [TIME_W-1:0] stamp_ff [HISTORY_ENTRIES];
   logic              pinned_ff [HISTORY_ENTRIES];

   // Walk state
   logic [IDX_W-1:0]  idx_ff;
   logic              free_ok_ff;
   logic [IDX_W-1:0]  free_slot_ff;
   logic              old_ok_ff;
   logic [IDX_W-1:0]  old_slot_ff;
   logic [TIME_W-1:0] old_age_ff;
   logic              result_ff;

   // Output register
   logic rsp_valid_ff;
   logic rsp_accept_ff;

   // Current entry evaluation
   logic              cur_valid;
   logic [TIME_W-1:0] cur_age;
   logic              cur_expired;
   logic              cur_hit;
   logic [IDX_W-1:0]  store_slot;

   assign cur_valid   = valid_ff[idx_ff];
   assign cur_age     = now_ff - stamp_ff[idx_ff];
   assign cur_expired = (cur_age >= {{(TIME_W-CSR_W){1'b0}}, hold_ff}) && !pinned_ff[idx_ff];
   assign cur_hit     = cur_valid && !cur_expired && (ent_id_ff[idx_ff] == id_ff);

   // Last free slot seen, else oldest, else entry 0
   assign store_slot = free_ok_ff ? free_slot_ff : (old_ok_ff ? old_slot_ff : '0);

   assign status.is_clear   = (func_ff == FUNC_CLEAR);
   assign status.foreign    = (src_ff != {{(ADDR_W-CSR_W){1'b0}}, target_ff});
   assign status.hit        = cur_hit;
   assign status.last_entry = (idx_ff == LAST_IDX);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_accept = rsp_accept_ff;

   // Configuration writes; unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         hold_ff   <= HOLD_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_TARGET_ADDRESS) target_ff <= csr_data;
         if (csr_index == CSR_HOLD_TIME)      hold_ff   <= csr_data;
      end
   end

   // Request latch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= req_func;
         src_ff     <= req_src_address;
         id_ff      <= req_packet_id;
         now_ff     <= req_now_ms;
         pin_new_ff <= req_link_connected && req_protect_mode && (req_packet_id != BEACON_ID);
      end
   end

   // Walk registers and result
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         free_ok_ff <= 1'b0;
         old_ok_ff  <= 1'b0;
         result_ff  <= 1'b0;
      end else if (cmd.capture) begin
         idx_ff     <= '0;
         free_ok_ff <= 1'b0;
         old_ok_ff  <= 1'b0;
         old_age_ff <= '0;
         result_ff  <= 1'b0;
      end else if (cmd.step) begin
         if (!status.last_entry) idx_ff <= idx_ff + 1'b1;
         if (!cur_valid || cur_expired) begin
            free_ok_ff   <= 1'b1;
            free_slot_ff <= idx_ff;
         end else if (!cur_hit && (cur_age > old_age_ff)) begin
            old_ok_ff   <= 1'b1;
            old_slot_ff <= idx_ff;
            old_age_ff  <= cur_age;
         end
      end else if (cmd.store) begin
         result_ff <= 1'b1;
      end
   end

   // History table valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_ENTRIES; i++) valid_ff[i] <= 1'b0;
      end else if (cmd.check && status.is_clear) begin
         for (int i = 0; i < HISTORY_ENTRIES; i++) valid_ff[i] <= 1'b0;
      end else if (cmd.step && cur_valid && cur_expired) begin
         valid_ff[idx_ff] <= 1'b0;
      end else if (cmd.store) begin
         valid_ff[store_slot] <= 1'b1;
      end
   end

   // History table payload
   always_ff @(posedge clock) begin
      if (cmd.step && cur_hit) begin
         stamp_ff[idx_ff] <= now_ff;
      end else if (cmd.store) begin
         ent_id_ff[store_slot] <= id_ff;
         stamp_ff[store_slot]  <= now_ff;
         pinned_ff[store_slot] <= pin_new_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_accept_ff <= result_ff;
   end

endmodule

[verif/dpf_accept_checker.sv]
`timescale 1ns / 100ps
// Checker for the duplicate packet filter: watches the request, result and
// register channels, keeps its own copy of the history table and compares
// every accept bit. Depends on dpf_pkg.
module dpf_accept_checker #(
   parameter int HISTORY_ENTRIES = dpf_pkg::HISTORY_ENTRIES_DFLT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_func,
   input  logic [dpf_pkg::ADDR_W-1:0]    req_src_address,
   input  logic [dpf_pkg::ID_W-1:0]      req_packet_id,
   input  logic [dpf_pkg::TIME_W-1:0]    req_now_ms,
   input  logic                          req_link_connected,
   input  logic                          req_protect_mode,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_accept,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [dpf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dpf_pkg::CSR_W-1:0]     csr_data,
   output int                            mismatch_count,
   output int                            awaiting_count
);
   import dpf_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] src_address;
      logic [ID_W-1:0]   packet_id;
      logic [TIME_W-1:0] now_ms;
      logic              link_connected;
      logic              protect_mode;
   } filter_req_type;

   // Shadow copy of the history table and the two registers
   logic              hist_live   [HISTORY_ENTRIES];
   logic [ID_W-1:0]   hist_id     [HISTORY_ENTRIES];
   logic [TIME_W-1:0] hist_stamp  [HISTORY_ENTRIES];
   logic              hist_pinned [HISTORY_ENTRIES];
   logic [CSR_W-1:0]  peer_addr;
   logic [CSR_W-1:0]  hold_ms;

   logic expected_accept [$];
   int   fail_tally = 0;

   // Work out the accept bit of one request and update the shadow table
   function automatic logic predict_accept(input filter_req_type r);
      int                free_slot;
      int                old_slot;
      logic [TIME_W-1:0] old_age;
      logic [TIME_W-1:0] age;
      free_slot = -1;
      old_slot  = -1;
      old_age   = '0;
      if (r.func == FUNC_CLEAR) begin
         for (int k = 0; k < HISTORY_ENTRIES; k++) hist_live[k] = 1'b0;
         return 1'b0;
      end
      if (r.src_address != {{(ADDR_W-CSR_W){1'b0}}, peer_addr}) return 1'b0;
      // walk in index order; expired entries stay freed even on a later hit
      for (int k = 0; k < HISTORY_ENTRIES; k++) begin
         if (hist_live[k]) begin
            age = r.now_ms - hist_stamp[k];
            if (age >= {{(TIME_W-CSR_W){1'b0}}, hold_ms} && !hist_pinned[k]) begin
               hist_live[k] = 1'b0;
               free_slot = k;
            end else begin
               if (hist_id[k] == r.packet_id) begin
                  hist_stamp[k] = r.now_ms;
                  return 1'b0;
               end
               if (age > old_age) begin
                  old_age  = age;
                  old_slot = k;
               end
            end
         end else begin
            free_slot = k;
         end
      end
      // no free entry: replace the oldest, entry 0 when none is strictly older
      if (free_slot < 0) free_slot = (old_slot < 0) ? 0 : old_slot;
      hist_live[free_slot]   = 1'b1;
      hist_id[free_slot]     = r.packet_id;
      hist_stamp[free_slot]  = r.now_ms;
      hist_pinned[free_slot] = r.link_connected && r.protect_mode &&
                               (r.packet_id != BEACON_ID);
      return 1'b1;
   endfunction

   function automatic void note_failure(input string what);
      fail_tally++;
      if (fail_tally <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
   endfunction

   // Results are checked before the new request is queued, since a request
   // can never be answered at the edge that takes it.
   always @(posedge clock) begin
      filter_req_type r;
      logic           want;
      if (reset) begin
         for (int k = 0; k < HISTORY_ENTRIES; k++) begin
            hist_live[k]   = 1'b0;
            hist_id[k]     = '0;
            hist_stamp[k]  = '0;
            hist_pinned[k] = 1'b0;
         end
         peer_addr = '0;
         hold_ms   = HOLD_RESET;
         expected_accept.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_accept.size() == 0) begin
               note_failure($sformatf("unexpected result, accept=%0b", rsp_accept));
            end else begin
               want = expected_accept.pop_front();
               if (rsp_accept !== want)
                  note_failure($sformatf("accept mismatch: expected %0b, got %0b",
                                         want, rsp_accept));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TARGET_ADDRESS: peer_addr = csr_data;
               CSR_HOLD_TIME:      hold_ms   = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            r.func           = req_func;
            r.src_address    = req_src_address;
            r.packet_id      = req_packet_id;
            r.now_ms         = req_now_ms;
            r.link_connected = req_link_connected;
            r.protect_mode   = req_protect_mode;
            expected_accept.push_back(predict_accept(r));
         end
      end
      awaiting_count <= expected_accept.size();
      mismatch_count <= fail_tally;
   end

endmodule

[verif/tb_duplicate_packet_filter_top.sv]
`timescale 1ns / 100ps
// Testbench top for the duplicate packet filter: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on dpf_pkg, duplicate_packet_filter_top and dpf_accept_checker.
module tb_duplicate_packet_filter_top;
   import dpf_pkg::*;

   localparam int HISTORY_ENTRIES = HISTORY_ENTRIES_DFLT;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 235;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES     = 2 * (HISTORY_ENTRIES + 4);
   localparam int CYCLE_LIMIT     = 400000;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TOP = '1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_func = FUNC_JUDGE;
   logic [ADDR_W-1:0]    req_src_address = '0;
   logic [ID_W-1:0]      req_packet_id = '0;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic                 req_link_connected = 1'b0;
   logic                 req_protect_mode = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_accept;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;

   int mismatch_count;
   int awaiting_count;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   int rsp_hold_count = 0;
   int rsp_hold_seen = 0;
   int rsp_stall_left = 0;

   duplicate_packet_filter_top #(.HISTORY_ENTRIES(HISTORY_ENTRIES)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_src_address(req_src_address), .req_packet_id(req_packet_id),
      .req_now_ms(req_now_ms), .req_link_connected(req_link_connected),
      .req_protect_mode(req_protect_mode),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_accept(rsp_accept),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   dpf_accept_checker #(.HISTORY_ENTRIES(HISTORY_ENTRIES)) accept_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_src_address(req_src_address), .req_packet_id(req_packet_id),
      .req_now_ms(req_now_ms), .req_link_connected(req_link_connected),
      .req_protect_mode(req_protect_mode),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_accept(rsp_accept),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatch_count(mismatch_count), .awaiting_count(awaiting_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off on each trigger
   always @(posedge clock) begin
      if (rsp_hold_seen != rsp_hold_count) begin
         rsp_hold_seen  <= rsp_hold_count;
         rsp_stall_left <= RSP_HOLD_CYCLES;
         rsp_ready      <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // Offer one request and hold it until taken; gaps follow at random
   task automatic issue_request(input logic func, input logic [ADDR_W-1:0] src,
                                input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now,
                                input logic conn, input logic prot);
      req_valid          <= 1'b1;
      req_func           <= func;
      req_src_address    <= src;
      req_packet_id      <= id;
      req_now_ms         <= now;
      req_link_connected <= conn;
      req_protect_mode   <= prot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stop offering until every request has been answered
   task automatic wait_until_answered();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting_count != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [CSR_W-1:0]  peer;
      logic [CSR_W-1:0]  hold;
      logic [ID_W-1:0]   id_base;
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] src;
      logic [TIME_W-1:0] ms_now;
      int                pick;
      int                span;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 17;
      rcv_idle_pct <= 67;
      @(posedge clock);

      // Directed: reset registers, peer 0, hold 200 ms
      issue_request(FUNC_JUDGE, 32'h0, 8'h00, 32'd0, 1'b0, 1'b0);
      issue_request(FUNC_JUDGE, 32'h0, 8'h00, 32'd10, 1'b0, 1'b0);
      // foreign: all ones, then only an upper address bit set
      issue_request(FUNC_JUDGE, 32'hFFFF_FFFF, 8'hAA, 32'd10, 1'b1, 1'b1);
      issue_request(FUNC_JUDGE, 32'h0001_0000, 8'h01, 32'd10, 1'b0, 1'b0);
      // a beacon is never pinned, an ordinary ID with link and protect is
      issue_request(FUNC_JUDGE, 32'h0, BEACON_ID, 32'd20, 1'b1, 1'b1);
      issue_request(FUNC_JUDGE, 32'h0, 8'h01, 32'd20, 1'b1, 1'b1);
      issue_request(FUNC_JUDGE, 32'h0, 8'h02, 32'd30, 1'b1, 1'b0);
      issue_request(FUNC_JUDGE, 32'h0, 8'h03, 32'd30, 1'b0, 1'b1);
      // table full: the oldest entry is replaced
      issue_request(FUNC_JUDGE, 32'h0, 8'h04, 32'd40, 1'b0, 1'b0);
      // stale entries freed ahead of the pinned hit
      issue_request(FUNC_JUDGE, 32'h0, 8'h01, 32'd400, 1'b0, 1'b0);
      // time runs back: stamps in the future count as very old
      issue_request(FUNC_JUDGE, 32'h0, 8'h02, 32'd100, 1'b0, 1'b0);
      issue_request(FUNC_JUDGE, 32'h0, 8'h03, 32'd5, 1'b0, 1'b0);
      // clear, after which the pinned ID is new again
      issue_request(FUNC_CLEAR, $urandom, ID_W'($urandom), $urandom, 1'b1, 1'b1);
      issue_request(FUNC_JUDGE, 32'h0, 8'h01, 32'd500, 1'b1, 1'b1);
      // every entry stamped at the same time: entry 0 gets replaced
      issue_request(FUNC_CLEAR, $urandom, ID_W'($urandom), $urandom, 1'b0, 1'b0);
      for (int k = 0; k < HISTORY_ENTRIES + 2; k++)
         issue_request(FUNC_JUDGE, 32'h0, ID_W'(8'h10 + k), 32'hFFFF_FFFF, 1'b0, 1'b0);
      issue_request(FUNC_JUDGE, 32'h0, 8'h10, 32'hFFFF_FFFF, 1'b0, 1'b0);
      // time wraps past zero
      issue_request(FUNC_JUDGE, 32'h0, 8'h14, 32'h0000_0010, 1'b0, 1'b0);

      // Random phases, each with its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin peer = CSR_W'($urandom); hold = 16'd1; end
            1: begin peer = 16'hFFFF; hold = 16'hFFFF; end
            2: begin peer = 16'h0000; hold = 16'd0; end
            3: begin peer = CSR_W'($urandom); hold = HOLD_RESET; end
            4: begin peer = CSR_W'($urandom); hold = CSR_W'($urandom_range(20, 2000)); end
            default: begin peer = 16'hFFFF; hold = 16'd50; end
         endcase
         wait_until_answered();
         write_reg(CSR_TARGET_ADDRESS, peer);
         write_reg(CSR_HOLD_TIME, hold);
         write_reg(CSR_IDX_W'($urandom_range(CSR_HOLD_TIME + 1, CSR_IDX_TOP)),
                   CSR_W'($urandom));
         // sender light / receiver heavy, then swapped, then no idling
         if (ph < 2) begin
            send_idle_pct = 17;
            rcv_idle_pct <= 67;
         end else if (ph < 4) begin
            send_idle_pct = 67;
            rcv_idle_pct <= 17;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct <= 0;
         end
         id_base = ID_W'($urandom_range(0, 248));
         ms_now  = (ph == 1) ? 32'hFFFF_FF00 : $urandom;
         span    = int'(hold);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 0 && n == 120) wait_until_answered();
            if ((ph == 1 || ph == 4) && n == 60) rsp_hold_count <= rsp_hold_count + 1;

            // time mostly creeps, sometimes leaps past the hold, rarely goes back
            pick = $urandom_range(99);
            if (pick < 75)      ms_now = ms_now + $urandom_range(0, span / 4 + 1);
            else if (pick < 93) ms_now = ms_now + $urandom_range(0, 2 * span + 2);
            else                ms_now = ms_now - $urandom_range(1, 3 * span + 10);

            pick = $urandom_range(99);
            if (pick < 10)      id = BEACON_ID;
            else if (pick < 25) id = ID_W'($urandom);
            else                id = id_base + ID_W'($urandom_range(0, 6));

            pick = $urandom_range(99);
            if (pick < 4) begin
               issue_request(FUNC_CLEAR, $urandom, ID_W'($urandom), $urandom,
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 9) begin
               issue_request(FUNC_JUDGE, $urandom, ID_W'($urandom), $urandom,
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
               src = {{(ADDR_W-CSR_W){1'b0}}, peer};
               // a near miss on one address bit now and then
               if ($urandom_range(99) < 6) src = src ^ (32'h1 << $urandom_range(0, 31));
               issue_request(FUNC_JUDGE, src, id, ms_now,
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
         end
      end

      wait_until_answered();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
